// ===== src/klt_pkg.sv =====
// Shared types and default sizes for the keyed LRU table.
// Used by klt_cell and keyed_lru_table; depends on nothing else.
package klt_pkg;

    localparam int ENTRIES_DEF      = 16;
    localparam int KEY_BITS_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 64;
    localparam int STAMP_BITS_DEF   = 32;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    // Control flags of the search token as it moves down the row of cells.
    typedef struct packed {
        logic active;
        logic op;
        logic hit;
        logic free_found;
    } t_scan_ctl;

    // Write request broadcast to all cells.
    typedef struct packed {
        logic en;
        logic fill;
    } t_wr_ctl;

endpackage

// ===== src/klt_cell.sv =====
// One table entry of the keyed LRU table plus one stage of the search row.
// Depends on klt_pkg for the token and write control structs.
module klt_cell import klt_pkg::*; #(
    parameter int SW           = 5,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    parameter int STAMP_BITS   = STAMP_BITS_DEF,
    parameter int CELL_IDX     = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_scan_ctl               i_ctl,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [SW-1:0]           i_hit_idx,
    input  logic [SW-1:0]           i_free_idx,
    input  logic [SW-1:0]           i_lru_idx,
    input  logic [STAMP_BITS-1:0]   i_lru_stamp,
    input  logic [PAYLOAD_BITS-1:0] i_path,
    input  logic [PAYLOAD_BITS-1:0] i_expect,
    output t_scan_ctl               o_ctl,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [SW-1:0]           o_hit_idx,
    output logic [SW-1:0]           o_free_idx,
    output logic [SW-1:0]           o_lru_idx,
    output logic [STAMP_BITS-1:0]   o_lru_stamp,
    output logic [PAYLOAD_BITS-1:0] o_path,
    output logic [PAYLOAD_BITS-1:0] o_expect,
    input  t_wr_ctl                 i_wr,
    input  logic [SW-1:0]           i_wr_idx,
    input  logic [KEY_BITS-1:0]     i_wr_key,
    input  logic [PAYLOAD_BITS-1:0] i_wr_path,
    input  logic [PAYLOAD_BITS-1:0] i_wr_expect,
    input  logic [STAMP_BITS-1:0]   i_wr_stamp
);

    localparam logic [SW-1:0] MY_IDX = SW'(CELL_IDX);

    logic                    r_valid;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_path;
    logic [PAYLOAD_BITS-1:0] r_expect;
    logic [STAMP_BITS-1:0]   r_stamp;

    t_scan_ctl               r_ctl,       n_ctl;
    logic [KEY_BITS-1:0]     r_tok_key;
    logic [SW-1:0]           r_hit_idx,   n_hit_idx;
    logic [SW-1:0]           r_free_idx,  n_free_idx;
    logic [SW-1:0]           r_lru_idx,   n_lru_idx;
    logic [STAMP_BITS-1:0]   r_lru_stamp, n_lru_stamp;
    logic [PAYLOAD_BITS-1:0] r_tok_path,  n_tok_path;
    logic [PAYLOAD_BITS-1:0] r_tok_exp,   n_tok_exp;

    logic match;
    logic wr_sel;

    assign match  = r_valid && (r_key == i_key);
    assign wr_sel = i_wr.en && (i_wr_idx == MY_IDX);

    always_comb begin
        n_ctl       = i_ctl;
        n_hit_idx   = i_hit_idx;
        n_free_idx  = i_free_idx;
        n_lru_idx   = i_lru_idx;
        n_lru_stamp = i_lru_stamp;
        n_tok_path  = i_path;
        n_tok_exp   = i_expect;
        // Once an earlier cell has matched, this cell only passes the token on.
        if (!i_ctl.hit) begin
            if (match) begin
                n_ctl.hit  = 1'b1;
                n_hit_idx  = MY_IDX;
                n_tok_path = r_path;
                n_tok_exp  = r_expect;
            end
            if (!r_valid && !i_ctl.free_found) begin
                n_ctl.free_found = 1'b1;
                n_free_idx       = MY_IDX;
            end
            // Strict compare keeps the lowest index among equal stamps.
            if (r_stamp < i_lru_stamp) begin
                n_lru_idx   = MY_IDX;
                n_lru_stamp = r_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            if (wr_sel && i_wr.fill) begin
                r_valid <= 1'b1;
            end
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_sel) begin
            r_path   <= i_wr_path;
            r_expect <= i_wr_expect;
            r_stamp  <= i_wr_stamp;
            if (i_wr.fill) begin
                r_key <= i_wr_key;
            end
        end
        r_tok_key   <= i_key;
        r_hit_idx   <= n_hit_idx;
        r_free_idx  <= n_free_idx;
        r_lru_idx   <= n_lru_idx;
        r_lru_stamp <= n_lru_stamp;
        r_tok_path  <= n_tok_path;
        r_tok_exp   <= n_tok_exp;
    end

    assign o_ctl       = r_ctl;
    assign o_key       = r_tok_key;
    assign o_hit_idx   = r_hit_idx;
    assign o_free_idx  = r_free_idx;
    assign o_lru_idx   = r_lru_idx;
    assign o_lru_stamp = r_lru_stamp;
    assign o_path      = r_tok_path;
    assign o_expect    = r_tok_exp;

endmodule

// ===== src/keyed_lru_table.sv =====
// Fully associative keyed table with timestamp LRU replacement.
// The search token steps through the row, one entry cell per cycle; at the end of
// the row it is resolved and the table written, then result and output are registered.
// A new item is accepted only when idle, after the last result is loaded for output.
// Reset (synchronous, active low) clears all valid bits, the occupancy count
// and the recency clock; no clearing pass is needed.
module keyed_lru_table import klt_pkg::*; #(
    parameter int ENTRIES      = ENTRIES_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    parameter int STAMP_BITS   = STAMP_BITS_DEF,
    localparam int SW          = $clog2(ENTRIES + 1),
    localparam int IN_W        = ((KEY_BITS + 2 * PAYLOAD_BITS + 7) / 8) * 8,
    localparam int OUT_W       = ((2 * SW + 2 * PAYLOAD_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // key_tag, path_handle, expect_handle (from bit 0 up), zero padded
    input  logic [IN_W-1:0]  s_axis_tdata,
    // operation
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // slot_index, path_out, expect_out, occupancy (from bit 0 up), zero padded
    output logic [OUT_W-1:0] m_axis_tdata,
    // hit
    output logic             m_axis_tuser
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [SW-1:0]         MISS_IDX  = SW'(ENTRIES);
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

    logic [1:0] r_state;

    logic                    r_op;
    logic [PAYLOAD_BITS-1:0] r_path;
    logic [PAYLOAD_BITS-1:0] r_expect;
    logic [STAMP_BITS-1:0]   r_clock, n_clock;
    logic [SW-1:0]           r_occ,   n_occ;

    logic [SW-1:0]           r_res_slot,   n_res_slot;
    logic                    r_res_hit,    n_res_hit;
    logic [PAYLOAD_BITS-1:0] r_res_path,   n_res_path;
    logic [PAYLOAD_BITS-1:0] r_res_expect, n_res_expect;

    logic                    r_out_valid;
    logic [SW-1:0]           r_out_slot;
    logic                    r_out_hit;
    logic [PAYLOAD_BITS-1:0] r_out_path;
    logic [PAYLOAD_BITS-1:0] r_out_expect;
    logic [SW-1:0]           r_out_occ;

    t_scan_ctl               ch_ctl     [0:ENTRIES];
    logic [KEY_BITS-1:0]     ch_key     [0:ENTRIES];
    logic [SW-1:0]           ch_hit_idx [0:ENTRIES];
    logic [SW-1:0]           ch_free_idx[0:ENTRIES];
    logic [SW-1:0]           ch_lru_idx [0:ENTRIES];
    logic [STAMP_BITS-1:0]   ch_lru_st  [0:ENTRIES];
    logic [PAYLOAD_BITS-1:0] ch_path    [0:ENTRIES];
    logic [PAYLOAD_BITS-1:0] ch_expect  [0:ENTRIES];

    t_wr_ctl       wr;
    logic [SW-1:0] wr_idx;

    logic in_xfer;
    logic out_load;
    logic tail;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign tail          = (r_state == S_SCAN) && ch_ctl[ENTRIES].active;
    assign out_load      = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // The token enters the first cell on the transfer edge itself.
    always_comb begin
        ch_ctl[0]            = '0;
        ch_ctl[0].active     = in_xfer;
        ch_ctl[0].op         = s_axis_tuser;
        ch_key[0]            = s_axis_tdata[KEY_BITS-1:0];
        ch_hit_idx[0]        = MISS_IDX;
        ch_free_idx[0]       = MISS_IDX;
        ch_lru_idx[0]        = '0;
        ch_lru_st[0]         = STAMP_MAX;
        ch_path[0]           = '0;
        ch_expect[0]         = '0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        klt_cell #(
            .SW           (SW),
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .STAMP_BITS   (STAMP_BITS),
            .CELL_IDX     (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ch_ctl[g]),
            .i_key       (ch_key[g]),
            .i_hit_idx   (ch_hit_idx[g]),
            .i_free_idx  (ch_free_idx[g]),
            .i_lru_idx   (ch_lru_idx[g]),
            .i_lru_stamp (ch_lru_st[g]),
            .i_path      (ch_path[g]),
            .i_expect    (ch_expect[g]),
            .o_ctl       (ch_ctl[g+1]),
            .o_key       (ch_key[g+1]),
            .o_hit_idx   (ch_hit_idx[g+1]),
            .o_free_idx  (ch_free_idx[g+1]),
            .o_lru_idx   (ch_lru_idx[g+1]),
            .o_lru_stamp (ch_lru_st[g+1]),
            .o_path      (ch_path[g+1]),
            .o_expect    (ch_expect[g+1]),
            .i_wr        (wr),
            .i_wr_idx    (wr_idx),
            .i_wr_key    (ch_key[ENTRIES]),
            .i_wr_path   (r_path),
            .i_wr_expect (r_expect),
            .i_wr_stamp  (n_clock)
        );
    end

    // Resolve the token at the end of the row and, for a record, issue the table write.
    always_comb begin
        t_scan_ctl t;
        t            = ch_ctl[ENTRIES];
        wr           = '0;
        wr_idx       = ch_hit_idx[ENTRIES];
        n_clock      = r_clock;
        n_occ        = r_occ;
        n_res_slot   = ch_hit_idx[ENTRIES];
        n_res_hit    = t.hit;
        n_res_path   = ch_path[ENTRIES];
        n_res_expect = ch_expect[ENTRIES];
        if (r_op == OP_RECORD) begin
            if (r_clock != STAMP_MAX) begin
                n_clock = r_clock + 1'b1;
            end
            if (!t.hit) begin
                wr.fill = 1'b1;
                if (t.free_found) begin
                    wr_idx = ch_free_idx[ENTRIES];
                    n_occ  = r_occ + 1'b1;
                end else begin
                    wr_idx = ch_lru_idx[ENTRIES];
                end
            end
            wr.en        = tail;
            n_res_slot   = wr_idx;
            n_res_path   = r_path;
            n_res_expect = r_expect;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clock     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (tail) begin
                        r_state <= S_DONE;
                        r_clock <= n_clock;
                        r_occ   <= n_occ;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op     <= s_axis_tuser;
            r_path   <= s_axis_tdata[KEY_BITS +: PAYLOAD_BITS];
            r_expect <= s_axis_tdata[KEY_BITS + PAYLOAD_BITS +: PAYLOAD_BITS];
        end
        if (tail) begin
            r_res_slot   <= n_res_slot;
            r_res_hit    <= n_res_hit;
            r_res_path   <= n_res_path;
            r_res_expect <= n_res_expect;
        end
        if (out_load) begin
            r_out_slot   <= r_res_slot;
            r_out_hit    <= r_res_hit;
            r_out_path   <= r_res_path;
            r_out_expect <= r_res_expect;
            r_out_occ    <= r_occ;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_occ, r_out_expect, r_out_path, r_out_slot});
    assign m_axis_tuser  = r_out_hit;

endmodule
